/* sv/dlf_pkg.sv */
// Shared types and constants of the IPv4 deny-list frame filter.
// Depends on nothing; the interfaces, the top and the bench import it.
package dlf_pkg;

   typedef logic [1:0]  op_type;
   typedef logic [1:0]  reason_type;

   localparam op_type OP_BYTE      = 2'd0;
   localparam op_type OP_ADD_ADDR  = 2'd1;
   localparam op_type OP_ADD_PORT  = 2'd2;
   localparam op_type OP_CLEAR     = 2'd3;

   localparam reason_type REASON_ALLOW = 2'd0;
   localparam reason_type REASON_ADDR  = 2'd1;
   localparam reason_type REASON_PORT  = 2'd2;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
   localparam logic [15:0] OFFSET_MAX     = 16'hFFFF;
   localparam logic [16:0] TCP_MIN_L4     = 17'd20;
   localparam logic [16:0] UDP_MIN_L4     = 17'd8;
   localparam logic [31:0] PORT_MAX       = 32'd65535;

   // Byte positions in the frame
   localparam logic [15:0] POS_ETYPE_HI   = 16'd12;
   localparam logic [15:0] POS_ETYPE_LO   = 16'd13;
   localparam logic [15:0] POS_IHL        = 16'd14;
   localparam logic [15:0] POS_PROTO      = 16'd23;
   localparam logic [15:0] POS_SRC_ADDR   = 16'd26;
   localparam logic [15:0] POS_DST_ADDR   = 16'd30;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADDR_SCAN,
      ST_PORT_SCAN,
      ST_DONE
   } state_type;

endpackage

/* sv/dlf_stream_if.sv */
// Valid/ready channels of the filter: request beats in, verdict beats out.
// Depends on dlf_pkg for the payload types.
interface dlf_req_if import dlf_pkg::*; ();
   logic        valid;
   logic        ready;
   op_type      op;
   logic [7:0]  data_byte;
   logic        last;
   logic [31:0] entry_value;

   modport source (output valid, op, data_byte, last, entry_value, input ready);
   modport sink   (input valid, op, data_byte, last, entry_value, output ready);
endinterface

interface dlf_rsp_if import dlf_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        allow;
   reason_type  reason;
   logic [31:0] source_address;
   logic [31:0] dest_address;
   logic [15:0] source_port;
   logic [15:0] dest_port;
   logic [7:0]  protocol;
   logic [31:0] address_drops;
   logic [31:0] port_drops;

   modport source (output valid, allow, reason, source_address, dest_address,
                   source_port, dest_port, protocol, address_drops, port_drops,
                   input ready);
   modport sink   (input valid, allow, reason, source_address, dest_address,
                   source_port, dest_port, protocol, address_drops, port_drops,
                   output ready);
endinterface

/* sv/dlf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dlf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* sv/ipv4_denylist_packet_filter_top.sv */
// IPv4 deny-list frame filter: frame bytes and table commands in, one verdict per frame out.
// Flow: a frame's last byte starts a scan of the address table (IPv4 only) and, for a nonzero
// dest port after an address miss, of the port table; the done state then loads the verdict
// register (held while the sink stalls).
// Throughput: 1 beat per cycle between frame ends; no beat is taken until the verdict loads.
// Reset (synchronous): tables empty, drop counters and frame state zero; no clearing pass.
module ipv4_denylist_packet_filter_top import dlf_pkg::*; #(
   parameter int ADDR_TABLE_DEPTH = 1024,
   parameter int PORT_TABLE_DEPTH = 1024
) (
   input logic        clock,
   input logic        reset,
   dlf_req_if.sink    req_chan,
   dlf_rsp_if.source  rsp_chan
);
   // RAM index and entry-count widths
   localparam int AAW = (ADDR_TABLE_DEPTH > 1) ? $clog2(ADDR_TABLE_DEPTH) : 1;
   localparam int PAW = (PORT_TABLE_DEPTH > 1) ? $clog2(PORT_TABLE_DEPTH) : 1;
   localparam int ACW = $clog2(ADDR_TABLE_DEPTH + 1);
   localparam int PCW = $clog2(PORT_TABLE_DEPTH + 1);
   localparam int SCW = (ACW > PCW) ? ACW : PCW;

   // ---------------------------------------------------------------------------
   // Sequencer and table bookkeeping
   // ---------------------------------------------------------------------------
   state_type        state_ff, state_in;
   logic [ACW-1:0]   addr_count_ff, addr_count_in;
   logic [PCW-1:0]   port_count_ff, port_count_in;
   logic [SCW-1:0]   scan_idx_ff, scan_idx_in;
   logic             cmp_valid_ff, cmp_valid_in;
   reason_type       reason_ff, reason_in;
   logic [31:0]      addr_drops_ff, addr_drops_in;
   logic [31:0]      port_drops_ff, port_drops_in;

   // Per-frame capture registers (cleared at every frame end)
   logic [15:0] offset_ff, offset_in;
   logic [15:0] ether_ff, ether_in;
   logic [3:0]  hwords_ff, hwords_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] src_addr_ff, src_addr_in;
   logic [31:0] dst_addr_ff, dst_addr_in;
   logic [15:0] src_port_ff, src_port_in;
   logic [15:0] dst_port_ff, dst_port_in;

   // Header fields of the frame being judged
   logic [31:0] key_sa_ff, key_da_ff;
   logic [15:0] key_sp_ff, key_dp_ff;
   logic [7:0]  key_pr_ff;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        out_allow_ff;
   reason_type  out_reason_ff;
   logic [31:0] out_sa_ff, out_da_ff, out_addr_drops_ff, out_port_drops_ff;
   logic [15:0] out_sp_ff, out_dp_ff;
   logic [7:0]  out_pr_ff;

   // Combinational helpers
   logic        accept, byte_take, frame_end, load_out;
   logic [7:0]  b;
   logic [15:0] l4_pos;
   logic [16:0] frame_len, hdr_end;
   logic        is_ipv4, ports_ok;

   logic                 addr_wr_en, port_wr_en;
   logic [31:0]          addr_rd_data;
   logic [15:0]          port_rd_data;
   logic                 addr_hit, port_hit;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept    = req_chan.valid && req_chan.ready;
   assign byte_take = accept && (req_chan.op == OP_BYTE);
   assign frame_end = byte_take && req_chan.last;
   assign b         = req_chan.data_byte;

   // ---------------------------------------------------------------------------
   // Byte capture: place the incoming byte into every header field it belongs to
   // ---------------------------------------------------------------------------
   always_comb begin
      ether_in    = ether_ff;
      hwords_in   = hwords_ff;
      proto_in    = proto_ff;
      src_addr_in = src_addr_ff;
      dst_addr_in = dst_addr_ff;
      src_port_in = src_port_ff;
      dst_port_in = dst_port_ff;

      if (offset_ff == POS_ETYPE_HI) ether_in[15:8] = b;
      if (offset_ff == POS_ETYPE_LO) ether_in[7:0]  = b;
      if (offset_ff == POS_IHL)      hwords_in      = b[3:0];
      if (offset_ff == POS_PROTO)    proto_in       = b;

      if (offset_ff == POS_SRC_ADDR)          src_addr_in[31:24] = src_addr_in[31:24] | b;
      if (offset_ff == POS_SRC_ADDR + 16'd1)  src_addr_in[23:16] = src_addr_in[23:16] | b;
      if (offset_ff == POS_SRC_ADDR + 16'd2)  src_addr_in[15:8]  = src_addr_in[15:8]  | b;
      if (offset_ff == POS_SRC_ADDR + 16'd3)  src_addr_in[7:0]   = src_addr_in[7:0]   | b;
      if (offset_ff == POS_DST_ADDR)          dst_addr_in[31:24] = dst_addr_in[31:24] | b;
      if (offset_ff == POS_DST_ADDR + 16'd1)  dst_addr_in[23:16] = dst_addr_in[23:16] | b;
      if (offset_ff == POS_DST_ADDR + 16'd2)  dst_addr_in[15:8]  = dst_addr_in[15:8]  | b;
      if (offset_ff == POS_DST_ADDR + 16'd3)  dst_addr_in[7:0]   = dst_addr_in[7:0]   | b;

      // L4 start follows the IHL, including one taken from this very byte
      l4_pos = ETH_HDR_LEN + {10'd0, hwords_in, 2'b00};
      if (offset_ff == l4_pos)          src_port_in[15:8] = b;
      if (offset_ff == l4_pos + 16'd1)  src_port_in[7:0]  = b;
      if (offset_ff == l4_pos + 16'd2)  dst_port_in[15:8] = b;
      if (offset_ff == l4_pos + 16'd3)  dst_port_in[7:0]  = b;

      // Saturate the position counter
      offset_in = (offset_ff != OFFSET_MAX) ? offset_ff + 16'd1 : offset_ff;

      frame_len = {1'b0, offset_ff} + 17'd1;
      hdr_end   = {1'b0, l4_pos};
      is_ipv4   = (frame_len >= {1'b0, ETH_HDR_LEN}) && (ether_in == ETHERTYPE_IPV4);
      ports_ok  = ((proto_in == PROTO_TCP) && (frame_len >= hdr_end + TCP_MIN_L4)) ||
                  ((proto_in == PROTO_UDP) && (frame_len >= hdr_end + UDP_MIN_L4));
   end

   always_ff @(posedge clock) begin
      if (reset || frame_end) begin
         offset_ff   <= '0;
         ether_ff    <= '0;
         hwords_ff   <= '0;
         proto_ff    <= '0;
         src_addr_ff <= '0;
         dst_addr_ff <= '0;
         src_port_ff <= '0;
         dst_port_ff <= '0;
      end else if (byte_take) begin
         offset_ff   <= offset_in;
         ether_ff    <= ether_in;
         hwords_ff   <= hwords_in;
         proto_ff    <= proto_in;
         src_addr_ff <= src_addr_in;
         dst_addr_ff <= dst_addr_in;
         src_port_ff <= src_port_in;
         dst_port_ff <= dst_port_in;
      end
   end

   // Latch the header fields of a finished frame; non-IPv4 frames report zeros
   always_ff @(posedge clock) begin
      if (frame_end) begin
         key_sa_ff <= is_ipv4 ? src_addr_in : 32'd0;
         key_da_ff <= is_ipv4 ? dst_addr_in : 32'd0;
         key_pr_ff <= is_ipv4 ? proto_in : 8'd0;
         key_sp_ff <= (is_ipv4 && ports_ok) ? src_port_in : 16'd0;
         key_dp_ff <= (is_ipv4 && ports_ok) ? dst_port_in : 16'd0;
      end
   end

   // ---------------------------------------------------------------------------
   // Deny tables: loads append at the entry count, a clear only drops the counts
   // ---------------------------------------------------------------------------
   assign addr_wr_en = accept && (req_chan.op == OP_ADD_ADDR) &&
                       (addr_count_ff < ACW'(ADDR_TABLE_DEPTH));
   assign port_wr_en = accept && (req_chan.op == OP_ADD_PORT) &&
                       (req_chan.entry_value != 32'd0) &&
                       (req_chan.entry_value <= PORT_MAX) &&
                       (port_count_ff < PCW'(PORT_TABLE_DEPTH));

   dlf_ram #(
      .WIDTH (32),
      .DEPTH (ADDR_TABLE_DEPTH)
   ) u_addr_table (
      .clock   (clock),
      .wr_en   (addr_wr_en),
      .wr_addr (addr_count_ff[AAW-1:0]),
      .wr_data (req_chan.entry_value),
      .rd_addr (scan_idx_ff[AAW-1:0]),
      .rd_data (addr_rd_data)
   );

   dlf_ram #(
      .WIDTH (16),
      .DEPTH (PORT_TABLE_DEPTH)
   ) u_port_table (
      .clock   (clock),
      .wr_en   (port_wr_en),
      .wr_addr (port_count_ff[PAW-1:0]),
      .wr_data (req_chan.entry_value[15:0]),
      .rd_addr (scan_idx_ff[PAW-1:0]),
      .rd_data (port_rd_data)
   );

   // Compare logic, one per table: one table entry per cycle against the latched key
   assign addr_hit = cmp_valid_ff &&
                     ((addr_rd_data == key_sa_ff) || (addr_rd_data == key_da_ff));
   assign port_hit = cmp_valid_ff && (port_rd_data == key_dp_ff);

   // ---------------------------------------------------------------------------
   // Sequencer: next state, scan pointer, verdict and counters
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      scan_idx_in   = scan_idx_ff;
      cmp_valid_in  = 1'b0;
      reason_in     = reason_ff;
      addr_count_in = addr_count_ff;
      port_count_in = port_count_ff;
      addr_drops_in = addr_drops_ff;
      port_drops_in = port_drops_ff;
      load_out      = 1'b0;

      if (addr_wr_en) addr_count_in = addr_count_ff + ACW'(1);
      if (port_wr_en) port_count_in = port_count_ff + PCW'(1);
      if (accept && (req_chan.op == OP_CLEAR)) begin
         addr_count_in = '0;
         port_count_in = '0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (frame_end) begin
               reason_in   = REASON_ALLOW;
               scan_idx_in = '0;
               state_in    = is_ipv4 ? ST_ADDR_SCAN : ST_DONE;
            end
         end
         ST_ADDR_SCAN: begin
            if (addr_hit) begin
               reason_in = REASON_ADDR;
               state_in  = ST_DONE;
            end else if (scan_idx_ff < SCW'(addr_count_ff)) begin
               // issue the next read; its data is compared next cycle
               scan_idx_in  = scan_idx_ff + SCW'(1);
               cmp_valid_in = 1'b1;
            end else if (!cmp_valid_ff) begin
               scan_idx_in = '0;
               state_in    = (key_dp_ff != 16'd0) ? ST_PORT_SCAN : ST_DONE;
            end
         end
         ST_PORT_SCAN: begin
            if (port_hit) begin
               reason_in = REASON_PORT;
               state_in  = ST_DONE;
            end else if (scan_idx_ff < SCW'(port_count_ff)) begin
               scan_idx_in  = scan_idx_ff + SCW'(1);
               cmp_valid_in = 1'b1;
            end else if (!cmp_valid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
               if (reason_ff == REASON_ADDR) addr_drops_in = addr_drops_ff + 32'd1;
               if (reason_ff == REASON_PORT) port_drops_in = port_drops_ff + 32'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load_out || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_idx_ff   <= '0;
         cmp_valid_ff  <= 1'b0;
         reason_ff     <= REASON_ALLOW;
         addr_count_ff <= '0;
         port_count_ff <= '0;
         addr_drops_ff <= '0;
         port_drops_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_idx_ff   <= scan_idx_in;
         cmp_valid_ff  <= cmp_valid_in;
         reason_ff     <= reason_in;
         addr_count_ff <= addr_count_in;
         port_count_ff <= port_count_in;
         addr_drops_ff <= addr_drops_in;
         port_drops_ff <= port_drops_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Result register: holds the verdict beat while the sink stalls
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_allow_ff      <= (reason_ff == REASON_ALLOW);
         out_reason_ff     <= reason_ff;
         out_sa_ff         <= key_sa_ff;
         out_da_ff         <= key_da_ff;
         out_sp_ff         <= key_sp_ff;
         out_dp_ff         <= key_dp_ff;
         out_pr_ff         <= key_pr_ff;
         out_addr_drops_ff <= addr_drops_in;
         out_port_drops_ff <= port_drops_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.allow          = out_allow_ff;
   assign rsp_chan.reason         = out_reason_ff;
   assign rsp_chan.source_address = out_sa_ff;
   assign rsp_chan.dest_address   = out_da_ff;
   assign rsp_chan.source_port    = out_sp_ff;
   assign rsp_chan.dest_port      = out_dp_ff;
   assign rsp_chan.protocol       = out_pr_ff;
   assign rsp_chan.address_drops  = out_addr_drops_ff;
   assign rsp_chan.port_drops     = out_port_drops_ff;

endmodule

/* tb/ipv4_denylist_packet_filter_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the IPv4 deny-list frame filter: random and directed beats,
// verdicts predicted in-bench and checked field by field.
// Depends on dlf_pkg, dlf_stream_if.sv and ipv4_denylist_packet_filter_top.sv.
module ipv4_denylist_packet_filter_top_tb;
   import dlf_pkg::*;

   localparam int ADDR_DEPTH   = 1024;
   localparam int PORT_DEPTH   = 1024;
   localparam int RESET_CYCLES = 4;
   localparam int RANDOM_BEATS = 1000;
   localparam int RANDOM_FRAMES = 25;
   // Worst case after the last verdict: a full address scan plus a full port scan.
   localparam int DRAIN_CYCLES = ADDR_DEPTH + PORT_DEPTH + 16;
   localparam int WATCHDOG_NS  = 8_000_000;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data_byte;
      logic        last;
      logic [31:0] entry_value;
      logic        burst;       // send with no gap ahead of it
   } beat_type;

   typedef struct packed {
      logic        allow;
      reason_type  reason;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [7:0]  protocol;
      logic [31:0] address_drops;
      logic [31:0] port_drops;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dlf_req_if req_if ();
   dlf_rsp_if rsp_if ();

   ipv4_denylist_packet_filter_top #(
      .ADDR_TABLE_DEPTH(ADDR_DEPTH),
      .PORT_TABLE_DEPTH(PORT_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #4 clock = ~clock;

   // Stimulus and expected verdicts
   beat_type    pending[$];
   verdict_type verdicts_due[$];
   logic [7:0]  frame_buf[$];
   int          beats_total;
   int          beats_taken;
   int          fail_count;

   logic [31:0] addr_pool[8];
   logic [15:0] port_pool[8];

   // Filter state as the bench tracks it
   logic [15:0] frm_offset;
   logic [15:0] frm_etype;
   logic [3:0]  frm_ihl;
   logic [7:0]  frm_proto;
   logic [31:0] frm_src;
   logic [31:0] frm_dst;
   logic [15:0] frm_sport;
   logic [15:0] frm_dport;
   logic [31:0] addr_deny[$];
   logic [15:0] port_deny[$];
   logic [31:0] addr_drops_seen;
   logic [31:0] port_drops_seen;

   function automatic bit addr_denied(input logic [31:0] a);
      foreach (addr_deny[i])
         if (addr_deny[i] == a) return 1'b1;
      return 1'b0;
   endfunction

   // Apply one accepted beat to the tracked state; queue a verdict when a frame ends.
   task automatic advance_filter(input beat_type it);
      int          pos;
      int          len;
      int          l4;
      int          l4_len;
      bit          hit;
      verdict_type v;
      case (it.op)
         OP_ADD_ADDR: begin
            if (addr_deny.size() < ADDR_DEPTH) addr_deny.push_back(it.entry_value);
         end
         OP_ADD_PORT: begin
            if (it.entry_value != 0 && it.entry_value <= PORT_MAX &&
                port_deny.size() < PORT_DEPTH)
               port_deny.push_back(it.entry_value[15:0]);
         end
         OP_CLEAR: begin
            addr_deny.delete();
            port_deny.delete();
         end
         default: begin
            pos = int'(frm_offset);
            if (pos == POS_ETYPE_HI) frm_etype[15:8] = it.data_byte;
            if (pos == POS_ETYPE_LO) frm_etype[7:0] = it.data_byte;
            if (pos == POS_IHL) frm_ihl = it.data_byte[3:0];
            if (pos == POS_PROTO) frm_proto = it.data_byte;
            if (pos >= POS_SRC_ADDR && pos <= POS_SRC_ADDR + 3)
               frm_src[8 * (POS_SRC_ADDR + 3 - pos) +: 8] = it.data_byte;
            if (pos >= POS_DST_ADDR && pos <= POS_DST_ADDR + 3)
               frm_dst[8 * (POS_DST_ADDR + 3 - pos) +: 8] = it.data_byte;
            // A byte may land in the header and a port at once when the IHL is small.
            l4 = ETH_HDR_LEN + int'(frm_ihl) * 4;
            if (pos == l4)     frm_sport[15:8] = it.data_byte;
            if (pos == l4 + 1) frm_sport[7:0]  = it.data_byte;
            if (pos == l4 + 2) frm_dport[15:8] = it.data_byte;
            if (pos == l4 + 3) frm_dport[7:0]  = it.data_byte;
            len = pos + 1;
            if (frm_offset != OFFSET_MAX) frm_offset++;
            if (it.last) begin
               v = '0;
               v.allow = 1'b1;
               v.reason = REASON_ALLOW;
               if (len >= ETH_HDR_LEN && frm_etype == ETHERTYPE_IPV4) begin
                  v.source_address = frm_src;
                  v.dest_address = frm_dst;
                  v.protocol = frm_proto;
                  l4_len = (len > l4) ? len - l4 : 0;
                  if ((frm_proto == PROTO_TCP && l4_len >= TCP_MIN_L4) ||
                      (frm_proto == PROTO_UDP && l4_len >= UDP_MIN_L4)) begin
                     v.source_port = frm_sport;
                     v.dest_port = frm_dport;
                  end
                  hit = 1'b0;
                  foreach (port_deny[i])
                     if (port_deny[i] == v.dest_port) hit = 1'b1;
                  if (addr_denied(v.source_address) || addr_denied(v.dest_address)) begin
                     v.allow = 1'b0;
                     v.reason = REASON_ADDR;
                     addr_drops_seen++;
                  end else if (v.dest_port != 0 && hit) begin
                     v.allow = 1'b0;
                     v.reason = REASON_PORT;
                     port_drops_seen++;
                  end
               end
               v.address_drops = addr_drops_seen;
               v.port_drops = port_drops_seen;
               verdicts_due.push_back(v);
               frm_offset = '0;
               frm_etype = '0;
               frm_ihl = '0;
               frm_proto = '0;
               frm_src = '0;
               frm_dst = '0;
               frm_sport = '0;
               frm_dport = '0;
            end
         end
      endcase
   endtask

   // Table command; data_byte and last are junk the block must ignore.
   task automatic queue_cmd(input op_type op, input logic [31:0] value);
      beat_type b;
      b.op = op;
      b.data_byte = 8'($urandom);
      b.last = 1'($urandom);
      b.entry_value = value;
      b.burst = 1'b0;
      pending.push_back(b);
   endtask

   // Move the next count bytes of frame_buf to the beat queue; flag the final one.
   task automatic queue_frame(input int count, input bit burst);
      beat_type b;
      for (int i = 0; i < count; i++) begin
         b.op = OP_BYTE;
         b.data_byte = frame_buf.pop_front();
         b.last = (frame_buf.size() == 0);
         b.entry_value = $urandom;
         b.burst = burst;
         pending.push_back(b);
      end
   endtask

   task automatic poke(input int pos, input logic [7:0] val);
      if (pos < frame_buf.size()) frame_buf[pos] = val;
   endtask

   // Build a frame of total bytes: random fill, then the header fields that fit.
   task automatic shape_frame(input logic [15:0] etype, input logic [3:0] ihl,
                              input logic [7:0] proto, input logic [31:0] src,
                              input logic [31:0] dst, input logic [15:0] sport,
                              input logic [15:0] dport, input int total);
      int l4;
      frame_buf.delete();
      for (int i = 0; i < total; i++) frame_buf.push_back(8'($urandom));
      l4 = ETH_HDR_LEN + int'(ihl) * 4;
      poke(int'(POS_ETYPE_HI), etype[15:8]);
      poke(int'(POS_ETYPE_LO), etype[7:0]);
      poke(int'(POS_IHL), {4'h4, ihl});
      poke(int'(POS_PROTO), proto);
      for (int k = 0; k < 4; k++) begin
         poke(int'(POS_SRC_ADDR) + k, src[8 * (3 - k) +: 8]);
         poke(int'(POS_DST_ADDR) + k, dst[8 * (3 - k) +: 8]);
      end
      // Ports go last so they win where they overlap the IPv4 header.
      poke(l4, sport[15:8]);
      poke(l4 + 1, sport[7:0]);
      poke(l4 + 2, dport[15:8]);
      poke(l4 + 3, dport[7:0]);
   endtask

   function automatic logic [31:0] pick_addr();
      if ($urandom_range(0, 2) == 0) return $urandom;
      return addr_pool[$urandom_range(0, 7)];
   endfunction

   function automatic logic [15:0] pick_port();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 16'($urandom);
         default: return port_pool[$urandom_range(0, 7)];
      endcase
   endfunction

   task automatic build_directed();
      logic [31:0] a;
      logic [31:0] b;
      a = $urandom;
      b = $urandom;
      queue_cmd(OP_CLEAR, $urandom);
      // Single byte, just short of an Ethernet header, exactly a header.
      shape_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, a, b, 16'd1, 16'd1, 1);
      queue_frame(frame_buf.size(), 1'b0);
      shape_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, a, b, 16'd1, 16'd1, 13);
      queue_frame(frame_buf.size(), 1'b0);
      shape_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, a, b, 16'd1, 16'd1, 14);
      queue_frame(frame_buf.size(), 1'b0);
      shape_frame(16'h86DD, 4'd5, PROTO_TCP, a, b, 16'd1, 16'd1, 60);
      queue_frame(frame_buf.size(), 1'b0);
      // Bad port loads are dropped; the two good ones sit at the port extremes.
      queue_cmd(OP_ADD_PORT, 32'd0);
      queue_cmd(OP_ADD_PORT, 32'h0001_0000);
      queue_cmd(OP_ADD_PORT, 32'hFFFF_FFFF);
      queue_cmd(OP_ADD_PORT, PORT_MAX);
      queue_cmd(OP_ADD_PORT, 32'd1);
      queue_cmd(OP_ADD_ADDR, 32'hFFFF_FFFF);
      shape_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, a, 32'hFFFF_FFFF, 16'd7, 16'd9, 54);
      queue_frame(frame_buf.size(), 1'b0);
      shape_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 32'hFFFF_FFFF, b, 16'd7, 16'd9, 42);
      queue_frame(frame_buf.size(), 1'b0);
      // Port thresholds: one byte short of the L4 minimum, then exactly at it.
      shape_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, a, b, 16'hFFFF, 16'hFFFF, 53);
      queue_frame(frame_buf.size(), 1'b0);
      shape_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, a, b, 16'hFFFF, 16'hFFFF, 54);
      queue_frame(frame_buf.size(), 1'b0);
      shape_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, a, b, 16'd0, 16'd1, 41);
      queue_frame(frame_buf.size(), 1'b0);
      shape_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, a, b, 16'd0, 16'd1, 42);
      queue_frame(frame_buf.size(), 1'b0);
      // IHL of zero: the source port high byte doubles as the IHL byte.
      shape_frame(ETHERTYPE_IPV4, 4'd0, PROTO_UDP, a, b, 16'h4000, 16'd1, 40);
      queue_frame(frame_buf.size(), 1'b0);
      shape_frame(ETHERTYPE_IPV4, 4'd15, PROTO_TCP, a, b, 16'd3, 16'hFFFF, 94);
      queue_frame(frame_buf.size(), 1'b0);
      shape_frame(ETHERTYPE_IPV4, 4'd5, 8'd1, a, b, 16'd3, 16'hFFFF, 60);
      queue_frame(frame_buf.size(), 1'b0);
      // A zero address matches the missing bytes of a bare 14-byte IPv4 frame.
      queue_cmd(OP_ADD_ADDR, 32'd0);
      shape_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, a, b, 16'd1, 16'd1, 14);
      queue_frame(frame_buf.size(), 1'b0);
      // Table commands in mid-frame leave the frame and the counters alone.
      shape_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, a, b, 16'd5, 16'hFFFF, 54);
      queue_frame(20, 1'b0);
      queue_cmd(OP_CLEAR, $urandom);
      queue_cmd(OP_ADD_PORT, PORT_MAX);
      queue_frame(frame_buf.size(), 1'b0);
      queue_cmd(OP_CLEAR, $urandom);
   endtask

   task automatic build_random();
      int start;
      int frames;
      int adds;
      int hdr_end;
      logic [3:0] ihl;
      logic [7:0] proto;
      logic [15:0] etype;
      start = pending.size();
      frames = 0;
      adds = 0;
      while (pending.size() - start < RANDOM_BEATS || frames < RANDOM_FRAMES) begin
         case ($urandom_range(0, 19))
            0, 1, 2: begin
               // Keep the tables short so the frame-end scans stay quick.
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: queue_cmd(OP_ADD_ADDR, pick_addr());
                  5, 6, 7: queue_cmd(OP_ADD_PORT, {16'd0, port_pool[$urandom_range(0, 7)]});
                  8: queue_cmd(OP_ADD_PORT, $urandom_range(0, 1) ? 32'd0
                                                    : ($urandom | 32'h0001_0000));
                  default: queue_cmd(OP_CLEAR, $urandom);
               endcase
               adds++;
               if (adds > 40) begin
                  queue_cmd(OP_CLEAR, $urandom);
                  adds = 0;
               end
            end
            17, 18: begin
               // Runt frame, usually tagged IPv4.
               shape_frame($urandom_range(0, 3) ? ETHERTYPE_IPV4 : 16'($urandom),
                           4'($urandom), 8'($urandom), $urandom, $urandom,
                           16'($urandom), 16'($urandom), $urandom_range(1, 15));
               queue_frame(frame_buf.size(), 1'b0);
               frames++;
            end
            19: begin
               // Noise: random header fields and length.
               shape_frame(16'($urandom), 4'($urandom), 8'($urandom), $urandom, $urandom,
                           16'($urandom), 16'($urandom), $urandom_range(1, 80));
               queue_frame(frame_buf.size(), 1'b0);
               frames++;
            end
            default: begin
               etype = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ETHERTYPE_IPV4;
               ihl = ($urandom_range(0, 3) != 0) ? 4'd5 : 4'($urandom);
               case ($urandom_range(0, 4))
                  0, 1: proto = PROTO_TCP;
                  2, 3: proto = PROTO_UDP;
                  default: proto = 8'($urandom);
               endcase
               hdr_end = ETH_HDR_LEN + int'(ihl) * 4;
               // Aim the length around the TCP and UDP minimums.
               case ($urandom_range(0, 5))
                  0: hdr_end += $urandom_range(0, 3);
                  1: hdr_end += $urandom_range(7, 9);
                  2: hdr_end += $urandom_range(19, 21);
                  3: hdr_end += $urandom_range(22, 48);
                  4: hdr_end = $urandom_range(14, 34);
                  default: hdr_end += $urandom_range(4, 18);
               endcase
               shape_frame(etype, ihl, proto, pick_addr(), pick_addr(), 16'($urandom),
                           pick_port(), hdr_end);
               queue_frame(frame_buf.size(), 1'b0);
               frames++;
            end
         endcase
      end
   endtask

   // Driver: offer pending beats, with a random gap ahead of each one.
   beat_type beat_on_bus;
   int       req_wait;
   int       req_calm;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_wait = 0;
         req_calm = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            advance_filter(beat_on_bus);
            beats_taken++;
         end
         // Hold the current beat until it is taken.
         if (!req_if.valid || req_if.ready) begin
            if (req_wait > 0) begin
               req_wait--;
               req_if.valid <= 1'b0;
            end else if (pending.size() > 0) begin
               beat_on_bus = pending.pop_front();
               req_if.op <= beat_on_bus.op;
               req_if.data_byte <= beat_on_bus.data_byte;
               req_if.last <= beat_on_bus.last;
               req_if.entry_value <= beat_on_bus.entry_value;
               req_if.valid <= 1'b1;
               // Draw the gap before the next beat; sometimes run flat out for a while.
               if (pending.size() > 0 && pending[0].burst) begin
                  req_wait = 0;
               end else if (req_calm > 0) begin
                  req_calm--;
                  req_wait = 0;
               end else begin
                  req_wait = $urandom_range(0, 19);
                  if ($urandom_range(0, 29) == 0) req_calm = $urandom_range(10, 150);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: take verdicts, stall at random after each one, check against the oldest due.
   verdict_type due;
   int          rsp_wait;
   int          rsp_calm;

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_wait = 0;
         rsp_calm = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (verdicts_due.size() == 0) begin
               $display("%0t: verdict expected none actual allow %0d reason %0d", $time,
                        rsp_if.allow, rsp_if.reason);
               fail_count++;
            end else begin
               due = verdicts_due.pop_front();
               check_field("allow", 32'(due.allow), 32'(rsp_if.allow));
               check_field("reason", 32'(due.reason), 32'(rsp_if.reason));
               check_field("source_address", due.source_address, rsp_if.source_address);
               check_field("dest_address", due.dest_address, rsp_if.dest_address);
               check_field("source_port", 32'(due.source_port), 32'(rsp_if.source_port));
               check_field("dest_port", 32'(due.dest_port), 32'(rsp_if.dest_port));
               check_field("protocol", 32'(due.protocol), 32'(rsp_if.protocol));
               check_field("address_drops", due.address_drops, rsp_if.address_drops);
               check_field("port_drops", due.port_drops, rsp_if.port_drops);
            end
            if (rsp_calm > 0) begin
               rsp_calm--;
               rsp_wait = 0;
            end else begin
               rsp_wait = $urandom_range(0, 19);
               if ($urandom_range(0, 19) == 0) rsp_calm = $urandom_range(5, 40);
            end
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.op = OP_BYTE;
      req_if.data_byte = '0;
      req_if.last = 1'b0;
      req_if.entry_value = '0;
      rsp_if.ready = 1'b0;
      beats_taken = 0;
      fail_count = 0;
      frm_offset = '0;
      frm_etype = '0;
      frm_ihl = '0;
      frm_proto = '0;
      frm_src = '0;
      frm_dst = '0;
      frm_sport = '0;
      frm_dport = '0;
      addr_drops_seen = '0;
      port_drops_seen = '0;

      addr_pool[0] = 32'hFFFF_FFFF;
      for (int i = 1; i < 8; i++) addr_pool[i] = $urandom;
      port_pool[0] = 16'd1;
      port_pool[1] = 16'hFFFF;
      for (int i = 2; i < 8; i++) port_pool[i] = 16'($urandom_range(1, 65535));

      build_directed();
      build_random();
      beats_total = pending.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Wait for every beat to go in and every verdict to come out, then let the
      // block settle long enough to show any stray verdict.
      while (beats_taken < beats_total) @(posedge clock);
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && verdicts_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(WATCHDOG_NS);
      $display("status: fail");
      $finish;
   end

endmodule
